>>> rtl/msp_seg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_seg_pkg
// shared types and constants of the serial frame segmenter
// ----------------------------------------------------------------------------
package msp_seg_pkg;

    // frame delimiters
    localparam logic [7:0] CH_START = 8'h24;   // '$'
    localparam logic [7:0] CH_V1    = 8'h4D;   // 'M'
    localparam logic [7:0] CH_V2    = 8'h58;   // 'X'

    // header positions
    localparam logic [2:0] POS_FIRST_HDR = 3'd2;
    localparam logic [2:0] POS_V1_SIZE   = 3'd3;
    localparam logic [2:0] POS_V2_SIZE_L = 3'd6;
    localparam logic [2:0] POS_V2_SIZE_H = 3'd7;

    // packet length register
    localparam logic [7:0] PKT_LEN_RESET = 8'd251;
    localparam logic [8:0] PKT_LEN_ZERO  = 9'd256;

    // result queue depth default
    localparam int OUT_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_KIND   = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       packet_end;
        logic       frame_end;
        logic       frame_kind;
        logic       run_last;
    } t_result;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic       pend;
        logic [7:0] cnt;
    } t_put;

endpackage

>>> rtl/msp_seg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_seg_core
// frame state machine and packet boundary marking, one byte per request
// ----------------------------------------------------------------------------
module msp_seg_core
    import msp_seg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output t_push      o_push
);

    t_phase      r_phase, n_phase;
    logic        r_kind, n_kind;
    logic [2:0]  r_hdr, n_hdr;
    logic [7:0]  r_size_low, n_size_low;
    logic [16:0] r_left, n_left;
    logic [7:0]  r_pkt, n_pkt;
    logic [7:0]  r_pkt_max;

    logic [8:0]  limit;
    logic [16:0] left_dec;
    logic        fend;
    t_put        put_a, put_b;

    function automatic t_put f_put(input logic [7:0] pc, input logic [8:0] lim,
                                   input logic fe);
        t_put       res;
        logic [8:0] cnt;
        cnt      = {1'b0, pc} + 9'd1;
        res.pend = (cnt >= lim) || fe;
        res.cnt  = res.pend ? 8'd0 : cnt[7:0];
        return res;
    endfunction

    assign limit    = (r_pkt_max == 8'd0) ? PKT_LEN_ZERO : {1'b0, r_pkt_max};
    assign left_dec = (r_left != 17'd0) ? r_left - 17'd1 : r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_max <= PKT_LEN_RESET;
        end else if (i_cfg_we) begin
            r_pkt_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_kind     <= 1'b0;
            r_hdr      <= 3'd0;
            r_size_low <= 8'd0;
            r_left     <= 17'd0;
            r_pkt      <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_hdr      <= n_hdr;
            r_size_low <= n_size_low;
            r_left     <= n_left;
            r_pkt      <= n_pkt;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_hdr      = r_hdr;
        n_size_low = r_size_low;
        n_left     = r_left;
        n_pkt      = r_pkt;
        o_push     = '0;
        fend       = 1'b0;
        put_a      = f_put(r_pkt, limit, 1'b0);
        put_b      = f_put(put_a.cnt, limit, 1'b0);
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == CH_START) n_phase = PH_KIND;
                end
                PH_KIND: begin
                    if (i_rx_byte == CH_V1 || i_rx_byte == CH_V2) begin
                        // new packet starts with the '$'
                        n_kind = (i_rx_byte == CH_V2);
                        put_a  = f_put(8'd0, limit, 1'b0);
                        put_b  = f_put(put_a.cnt, limit, 1'b0);
                        o_push.num = 2'd2;
                        o_push.r0  = '{CH_START, put_a.pend, 1'b0, n_kind, 1'b0};
                        o_push.r1  = '{i_rx_byte, put_b.pend, 1'b0, n_kind, 1'b1};
                        n_pkt   = put_b.cnt;
                        n_hdr   = POS_FIRST_HDR;
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_HEADER: begin
                    o_push.num = 2'd1;
                    o_push.r0  = '{i_rx_byte, put_a.pend, 1'b0, r_kind, 1'b1};
                    n_pkt      = put_a.cnt;
                    if (!r_kind) begin
                        if (r_hdr == POS_V1_SIZE) begin
                            n_left  = {9'd0, i_rx_byte} + 17'd2;
                            n_phase = PH_BODY;
                        end else begin
                            n_hdr = r_hdr + 3'd1;
                        end
                    end else begin
                        if (r_hdr == POS_V2_SIZE_L) n_size_low = i_rx_byte;
                        if (r_hdr == POS_V2_SIZE_H) begin
                            n_left  = {1'b0, i_rx_byte, r_size_low} + 17'd1;
                            n_phase = PH_BODY;
                        end else begin
                            n_hdr = r_hdr + 3'd1;
                        end
                    end
                end
                PH_BODY: begin
                    fend       = (left_dec == 17'd0);
                    put_a      = f_put(r_pkt, limit, fend);
                    o_push.num = 2'd1;
                    o_push.r0  = '{i_rx_byte, put_a.pend, fend, r_kind, 1'b1};
                    n_pkt      = put_a.cnt;
                    n_left     = left_dec;
                    if (fend) n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

endmodule

>>> rtl/msp_seg_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_seg_outq
// small result queue, takes up to two results a cycle and gives one while i_ready is high
// ----------------------------------------------------------------------------
module msp_seg_outq
    import msp_seg_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] SPACE_LIM = CW'(DEPTH - 2);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   wr_nxt;
    logic            pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_nxt   = f_inc(r_wr);
    assign o_valid  = (r_count != '0);
    assign o_space  = (r_count <= SPACE_LIM);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.num == 2'd2) r_mem[wr_nxt] <= i_push.r1;
    end

    always_comb begin
        n_rd    = pop ? f_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push.num) - CW'(pop);
        case (i_push.num)
            2'd1:    n_wr = wr_nxt;
            2'd2:    n_wr = f_inc(wr_nxt);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/msp_frame_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_frame_segmenter
// serial byte stream to frame bytes with radio packet boundaries
// ----------------------------------------------------------------------------
// usage
//   rx channel: one serial byte per request (i_rx_valid / o_rx_ready)
//   tx channel: one frame byte per request with packet_end, frame_end,
//     frame_kind and run_last flags (o_tx_valid / i_tx_ready)
//   cfg: i_cfg_we writes i_cfg_wdata into the packet length register,
//     zero means 256 bytes per packet
//   order: the results of an accepted byte are registered in the result queue
//   throughput: one rx byte per cycle while the result queue has two free
//     slots; the tx side gives one result per cycle while i_tx_ready is high,
//     so a kind byte, which makes two results, needs two tx transfers; the
//     drain of the queue sets the sustained rate
//   reset: queue emptied, framer hunting for '$', packet length 251
//   stall: results wait in the queue of OUT_DEPTH entries; rx ready drops
//     when fewer than two slots are free and returns once the receiver drains
// ----------------------------------------------------------------------------
module msp_frame_segmenter
    import msp_seg_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF   // at least 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // serial side
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // radio side
    output logic       o_tx_valid,
    input  logic       i_tx_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_packet_end,
    output logic       o_frame_end,
    output logic       o_frame_kind,
    output logic       o_run_last,
    // packet length register
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_push   push;
    t_result result;
    logic    space;
    logic    accept;

    // an rx request is taken only when both results of a kind byte fit
    assign o_rx_ready = space;
    assign accept     = i_rx_valid && space;

    // framer: state update and results of the accepted byte in the same cycle
    msp_seg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push)
    );

    // result queue parts the rx side from tx stalls
    msp_seg_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_tx_valid),
        .i_ready  (i_tx_ready),
        .o_result (result)
    );

    assign o_tx_byte    = result.tx_byte;
    assign o_packet_end = result.packet_end;
    assign o_frame_end  = result.frame_end;
    assign o_frame_kind = result.frame_kind;
    assign o_run_last   = result.run_last;

endmodule

>>> rtl/msp_seg_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_seg_chk
// port level checks of the frame segmenter
// ----------------------------------------------------------------------------
module msp_seg_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_tx_valid,
    input logic       i_tx_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_packet_end,
    input logic       o_frame_end,
    input logic       o_frame_kind,
    input logic       o_run_last,
    input logic       i_cfg_we,
    input logic [7:0] i_cfg_wdata
);

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tx_valid)
        else $error("tx valid after reset");

    // a frame end always closes its packet
    a_fend_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && o_frame_end |-> o_packet_end)
        else $error("frame end without packet end");

    // frame end comes from a single result byte
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && o_frame_end |-> o_run_last)
        else $error("frame end not last of its run");

    // the second result of a pair is already queued
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && i_tx_ready && !o_run_last |=> o_tx_valid && o_run_last)
        else $error("second result of a pair missing");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !i_tx_ready |=> o_tx_valid && $stable(o_tx_byte)
            && $stable(o_packet_end) && $stable(o_frame_end)
            && $stable(o_frame_kind) && $stable(o_run_last))
        else $error("stalled result changed");

endmodule

bind msp_frame_segmenter msp_seg_chk u_chk (.*);
